>>> sv/sia_pkg.sv
`timescale 1ns / 1ps

package sia_pkg;

   localparam int ADDR_W      = 48;
   localparam int SIZE_W      = 12;
   localparam int CNT_W       = 8;
   localparam int KIND_W      = 2;
   localparam int MAX_OBJECTS = 255;
   localparam int IDX_W       = $clog2(MAX_OBJECTS);
   localparam int PROD_W      = IDX_W + SIZE_W;
   localparam int QUO_W       = IDX_W;
   localparam int STEP_W      = $clog2(QUO_W);
   localparam int CSR_IDX_W   = 2;

   localparam logic [IDX_W-1:0] END_MARK = IDX_W'(MAX_OBJECTS);

   localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FREE   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FORMAT = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL = 2'd2;

   localparam logic [SIZE_W-1:0] SIZE_RESET  = 12'd16;
   localparam logic [CNT_W-1:0]  TOTAL_RESET = 8'd1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_FORMAT,
      ST_ALLOC_MUL,
      ST_ALLOC_ADD,
      ST_FREE_SUB,
      ST_FREE_CHK,
      ST_FREE_DIV,
      ST_FREE_PUSH,
      ST_POST
   } state_type;

   typedef struct packed {
      logic start;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

endpackage

>>> sv/sia_if.sv
`timescale 1ns / 1ps

interface sia_req_if;
   logic                        valid;
   logic                        ready;
   logic [sia_pkg::KIND_W-1:0]  kind;
   logic [sia_pkg::ADDR_W-1:0]  address;

   modport source (output valid, output kind, output address, input ready);
   modport sink   (input valid, input kind, input address, output ready);
endinterface

interface sia_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        ok;
   logic [sia_pkg::ADDR_W-1:0]  object_address;
   logic [sia_pkg::CNT_W-1:0]   in_use;

   modport source (output valid, output ok, output object_address, output in_use,
                   input ready);
   modport sink   (input valid, input ok, input object_address, input in_use,
                   output ready);
endinterface

>>> sv/sia_divider.sv
`timescale 1ns / 1ps

module sia_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  sia_pkg::div_ctl_type         ctl,
   input  logic [sia_pkg::PROD_W-1:0]   dividend,
   input  logic [sia_pkg::SIZE_W-1:0]   divisor,
   output sia_pkg::div_sts_type         sts,
   output logic [sia_pkg::QUO_W-1:0]    quotient
);
   import sia_pkg::*;

   logic              running_ff, running_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [PROD_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [PROD_W:0]   trial;
   logic              take;

   // The caller guarantees the quotient fits in QUO_W bits, so a restoring
   // division over QUO_W steps, most significant bit first, is exact.
   assign trial = {1'b0, rem_ff} - ({1'b0, PROD_W'(divisor)} << step_ff);
   assign take  = ~trial[PROD_W];

   always_comb begin
      running_in = running_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      if (ctl.start) begin
         running_in = 1'b1;
         step_in    = STEP_W'(QUO_W - 1);
         rem_in     = dividend;
         quo_in     = '0;
      end else if (running_ff) begin
         if (take) begin
            rem_in = trial[PROD_W-1:0];
         end
         quo_in[step_ff] = take;
         if (step_ff == '0) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
         step_ff    <= '0;
      end else begin
         running_ff <= running_in;
         done_ff    <= done_in;
         step_ff    <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign sts.busy = running_ff;
   assign sts.done = done_ff;
   assign quotient = quo_ff;

endmodule

>>> sv/slab_index_free_list_allocator.sv
`timescale 1ns / 1ps

// Channel     Direction  Beat contents
// req_chan    in         kind, address
// rsp_chan    out        ok, object_address, in_use
// csr_*       in         csr_we, csr_index, csr_wdata (no read-back)
//
// One request is worked on at a time; req_chan.ready is high only when idle.
// Allocate makes one pass through the shared multiplier, then uses a
// registered read of the link memory. Free runs the 8-step iterative divider.
// Format makes one link memory write per cycle. A finished result sits in the
// output register while the next request is accepted; the block stalls only
// if a second result is ready before the first beat is taken. Reset is
// synchronous; the link memory is not cleared, format writes it.

module slab_index_free_list_allocator (
   input  logic                             clock,
   input  logic                             reset,
   sia_req_if.sink                          req_chan,
   sia_rsp_if.source                        rsp_chan,
   input  logic                             csr_we,
   input  logic [sia_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sia_pkg::ADDR_W-1:0]       csr_wdata
);
   import sia_pkg::*;

   state_type state_ff, state_in;

   logic [ADDR_W-1:0] base_ff;
   logic [SIZE_W-1:0] size_ff;
   logic [CNT_W-1:0]  total_ff;

   logic [KIND_W-1:0] kind_ff;
   logic [ADDR_W-1:0] addr_ff;

   logic [IDX_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]  alloc_ff, alloc_in;
   logic              fmt_ff, fmt_in;
   logic [IDX_W-1:0]  sweep_ff, sweep_in;

   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [IDX_W-1:0]  mul_a;
   logic [ADDR_W-1:0] diff_ff, diff_in;
   logic              borrow_ff, borrow_in;

   logic              res_ok_ff, res_ok_in;
   logic [ADDR_W-1:0] res_obj_ff, res_obj_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_ok_ff, rsp_ok_in;
   logic [ADDR_W-1:0] rsp_obj_ff, rsp_obj_in;
   logic [CNT_W-1:0]  rsp_use_ff, rsp_use_in;

   logic [IDX_W-1:0]  next_free_ff [MAX_OBJECTS];
   logic [IDX_W-1:0]  rd_ff;
   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   logic [IDX_W-1:0]  mem_wdata;

   logic              req_fire;
   logic              out_free;
   logic              alloc_ok;
   logic              free_pre_ok;
   logic              in_range;
   logic              sweep_last;
   logic [IDX_W:0]    sweep_next;

   div_ctl_type       div_ctl;
   div_sts_type       div_sts;
   logic [QUO_W-1:0]  div_quo;

   assign req_fire   = req_chan.valid && req_chan.ready;
   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign alloc_ok   = fmt_ff && (alloc_ff < total_ff) && (head_ff < total_ff);
   assign free_pre_ok = fmt_ff && (alloc_ff != '0) && (size_ff != '0);
   assign sweep_next = {1'b0, sweep_ff} + 1'b1;
   assign sweep_last = (sweep_next == {1'b0, total_ff});

   // A free address is in range when the offset lies below count * size; the
   // product comes out of the shared multiplier one state earlier.
   assign in_range = !borrow_ff && (diff_ff[ADDR_W-1:PROD_W] == '0) &&
                     (diff_ff[PROD_W-1:0] < prod_ff);

   // Shared multiplier: head * size for allocate, count * size otherwise.
   assign mul_a   = (state_ff == ST_ALLOC_MUL) ? head_ff : total_ff;
   assign prod_in = PROD_W'(mul_a) * PROD_W'(size_ff);

   assign div_ctl.start = (state_ff == ST_FREE_CHK) && in_range;

   sia_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (diff_ff[PROD_W-1:0]),
      .divisor  (size_ff),
      .sts      (div_sts),
      .quotient (div_quo)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (kind_ff)
               KIND_FORMAT: state_in = (total_ff == '0) ? ST_POST : ST_FORMAT;
               KIND_ALLOC:  state_in = alloc_ok ? ST_ALLOC_MUL : ST_POST;
               KIND_FREE:   state_in = free_pre_ok ? ST_FREE_SUB : ST_POST;
               default:     state_in = ST_POST;
            endcase
         end
         ST_FORMAT: begin
            if (sweep_last) begin
               state_in = ST_POST;
            end
         end
         ST_ALLOC_MUL: state_in = ST_ALLOC_ADD;
         ST_ALLOC_ADD: state_in = ST_POST;
         ST_FREE_SUB:  state_in = ST_FREE_CHK;
         ST_FREE_CHK:  state_in = in_range ? ST_FREE_DIV : ST_POST;
         ST_FREE_DIV: begin
            if (div_sts.done) begin
               state_in = ST_FREE_PUSH;
            end
         end
         ST_FREE_PUSH: state_in = ST_POST;
         ST_POST: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      head_in      = head_ff;
      alloc_in     = alloc_ff;
      fmt_in       = fmt_ff;
      sweep_in     = sweep_ff;
      diff_in      = diff_ff;
      borrow_in    = borrow_ff;
      res_ok_in    = res_ok_ff;
      res_obj_in   = res_obj_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_obj_in   = rsp_obj_ff;
      rsp_use_in   = rsp_use_ff;
      mem_we       = 1'b0;
      mem_waddr    = sweep_ff;
      mem_wdata    = END_MARK;
      case (state_ff)
         ST_DISPATCH: begin
            res_ok_in  = 1'b0;
            res_obj_in = '0;
            sweep_in   = '0;
            // Formatting an empty slab leaves an empty list.
            if (kind_ff == KIND_FORMAT && total_ff == '0) begin
               head_in   = '0;
               alloc_in  = '0;
               fmt_in    = 1'b1;
               res_ok_in = 1'b1;
            end
         end
         ST_FORMAT: begin
            mem_we    = 1'b1;
            mem_waddr = sweep_ff;
            mem_wdata = sweep_last ? END_MARK : sweep_next[IDX_W-1:0];
            sweep_in  = sweep_next[IDX_W-1:0];
            if (sweep_last) begin
               head_in   = '0;
               alloc_in  = '0;
               fmt_in    = 1'b1;
               res_ok_in = 1'b1;
            end
         end
         ST_ALLOC_ADD: begin
            res_obj_in = base_ff + ADDR_W'(prod_ff);
            res_ok_in  = 1'b1;
            head_in    = rd_ff;
            alloc_in   = alloc_ff + 1'b1;
         end
         ST_FREE_SUB: begin
            {borrow_in, diff_in} = {1'b0, addr_ff} - {1'b0, base_ff};
         end
         ST_FREE_PUSH: begin
            mem_we    = 1'b1;
            mem_waddr = div_quo;
            mem_wdata = head_ff;
            head_in   = div_quo;
            alloc_in  = alloc_ff - 1'b1;
            res_ok_in = 1'b1;
         end
         ST_POST: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = res_ok_ff;
               rsp_obj_in   = res_obj_ff;
               rsp_use_in   = alloc_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         base_ff      <= '0;
         size_ff      <= SIZE_RESET;
         total_ff     <= TOTAL_RESET;
         head_ff      <= '0;
         alloc_ff     <= '0;
         fmt_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         alloc_ff     <= alloc_in;
         fmt_ff       <= fmt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_BASE:  base_ff  <= csr_wdata;
               CSR_SIZE:  size_ff  <= csr_wdata[SIZE_W-1:0];
               CSR_TOTAL: total_ff <= csr_wdata[CNT_W-1:0];
               default: begin
               end
            endcase
         end
      end
      if (req_fire) begin
         kind_ff <= req_chan.kind;
         addr_ff <= req_chan.address;
      end
      sweep_ff   <= sweep_in;
      prod_ff    <= prod_in;
      diff_ff    <= diff_in;
      borrow_ff  <= borrow_in;
      res_ok_ff  <= res_ok_in;
      res_obj_ff <= res_obj_in;
      rsp_ok_ff  <= rsp_ok_in;
      rsp_obj_ff <= rsp_obj_in;
      rsp_use_ff <= rsp_use_in;
   end

   // Link memory: one write port, one registered read port at the list head.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         next_free_ff[mem_waddr] <= mem_wdata;
      end
      rd_ff <= next_free_ff[head_ff];
   end

   assign req_chan.ready          = (state_ff == ST_IDLE);
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.ok             = rsp_ok_ff;
   assign rsp_chan.object_address = rsp_obj_ff;
   assign rsp_chan.in_use         = rsp_use_ff;

endmodule

>>> sv/sia_checker.sv
`timescale 1ns / 1ps

module sia_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_ok,
   input logic [sia_pkg::ADDR_W-1:0]  rsp_object_address
);
   import sia_pkg::*;

   // No result is presented in the cycle after reset.
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat presented right after reset");

   // A request is worked on alone: the beat after acceptance is not taken.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while another is in progress");

   // A failed item never reports an object address.
   a_fail_no_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ok) |-> (rsp_object_address == '0))
      else $error("failed result carries a nonzero address");

   // A result beat stays until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result beat withdrawn before it was taken");

endmodule

bind slab_index_free_list_allocator sia_checker u_sia_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_chan.valid),
   .req_ready          (req_chan.ready),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_ok             (rsp_chan.ok),
   .rsp_object_address (rsp_chan.object_address)
);
